>>> rtl/stmf_pkg.sv
// Shared types and constants for the sliding trimmed-mean filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stmf_pkg;

  localparam int unsigned SAMPLE_W         = 16;
  localparam int unsigned CFG_W            = 6;
  localparam int unsigned MIN_WINDOW       = 3;
  localparam int unsigned WINDOW_LEN_RESET = 5;

  // Handshake status of the iterative divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/stmf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on stmf_pkg.
`timescale 1ns / 1ps

module stmf_ram
  import stmf_pkg::*;
#(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/stmf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on stmf_pkg (div_status_t).
`timescale 1ns / 1ps

module stmf_div
  import stmf_pkg::*;
#(
  parameter int unsigned NUM_W = 21,
  parameter int unsigned DEN_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output div_status_t      status_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned ITER_W = $clog2(NUM_W + 1);

  logic [ITER_W-1:0] iter_q;
  logic              busy_q, done_q;
  logic [DEN_W-1:0]  rem_q, den_q;
  logic [NUM_W-1:0]  quo_q;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             geq;

  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    geq    = ~diff[DEN_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= ITER_W'(NUM_W);
      end else if (busy_q) begin
        iter_q <= iter_q - ITER_W'(1);
        if (iter_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= geq ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], geq};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

>>> rtl/sliding_trimmed_mean_filter_core.sv
// Top level of the sliding trimmed-mean filter: sequencer, window store, accumulator.
// Depends on stmf_pkg, stmf_ram and stmf_div.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   channel_i, sample_i
//  out      output     out_valid_o / out_ready_i filtered_o
//  cfg      input      cfg_we_i (no wait)        cfg_wdata_i (window length)
//
// Each word walks its n entries (n = clamped window length) through the
// single-port-read RAM, then the bit-serial divider works on the SUM_W-bit
// sum (SUM_W = 16 + clog2(WINDOW_MAX+1)).
// After reset a clearing pass zeroes the store, all NUM_CHANNELS * WINDOW_MAX entries.
// in_ready_o is high only while idle; a finished word waits in the output
// register, and the next word may be taken while it does.

module sliding_trimmed_mean_filter_core
  import stmf_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = 32,
  parameter int unsigned NUM_CHANNELS = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                channel_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] filtered_o,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned DEPTH  = NUM_CHANNELS * WINDOW_MAX;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CNT_W  = $clog2(WINDOW_MAX + 2);
  localparam int unsigned SUM_W  = SAMPLE_W + LEN_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT,
    ST_TRIM,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   clr_q;
  logic [CFG_W-1:0]    wlen_q;
  logic [LEN_W-1:0]    n_cfg, n_q;
  logic [CNT_W-1:0]    cnt_q, n_plus;
  logic [ADDR_W-1:0]   base_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                bad_q;
  logic [SUM_W-1:0]    sum_q, trimmed;
  logic [SAMPLE_W-1:0] lo_q, hi_q, filt_q, val;
  logic                out_valid_q;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  logic                div_start;
  div_status_t         div_st;
  logic [SUM_W-1:0]    quotient;

  // clamp of the window length register
  always_comb begin
    if (wlen_q < CFG_W'(MIN_WINDOW)) begin
      n_cfg = LEN_W'(MIN_WINDOW);
    end else if (int'(wlen_q) > WINDOW_MAX) begin
      n_cfg = LEN_W'(WINDOW_MAX);
    end else begin
      n_cfg = LEN_W'(wlen_q);
    end
  end

  assign n_plus = CNT_W'(n_q) + CNT_W'(1);
  // new sample goes in last, on the final walk step
  assign val    = (cnt_q == n_plus) ? sample_q : ram_rdata;

  // Window walk: step k reads entry k and writes entry k-1's data to k-2
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_q + ADDR_W'(cnt_q - CNT_W'(2));
    ram_wdata = val;
    ram_raddr = base_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_SHIFT: begin
        ram_we = (cnt_q >= CNT_W'(2));
        if (cnt_q < CNT_W'(n_q)) begin
          ram_raddr = base_q + ADDR_W'(cnt_q);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign trimmed   = sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
  assign div_start = (state_q == ST_TRIM);

  stmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  stmf_div #(
    .NUM_W(SUM_W),
    .DEN_W(LEN_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(trimmed),
    .divisor_i (n_q - LEN_W'(2)),
    .status_o  (div_st),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      wlen_q      <= CFG_W'(WINDOW_LEN_RESET);
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      sample_q    <= '0;
      base_q      <= '0;
      n_q         <= '0;
      sum_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      filt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
      // the output step refills the register itself
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            sample_q <= sample_i;
            base_q   <= ADDR_W'(channel_i) * ADDR_W'(WINDOW_MAX);
            n_q      <= n_cfg;
            cnt_q    <= CNT_W'(1);
            sum_q    <= '0;
            lo_q     <= '1;
            hi_q     <= '0;
            bad_q    <= (int'(channel_i) >= NUM_CHANNELS);
            state_q  <= (int'(channel_i) >= NUM_CHANNELS) ? ST_OUT : ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (cnt_q >= CNT_W'(2)) begin
            sum_q <= sum_q + SUM_W'(val);
            if (val < lo_q) begin
              lo_q <= val;
            end
            if (val > hi_q) begin
              hi_q <= val;
            end
          end
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == n_plus) begin
            state_q <= ST_TRIM;
          end
        end
        ST_TRIM: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_st.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            filt_q      <= bad_q ? '0 : quotient[SAMPLE_W-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign filtered_o  = filt_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again straight after accept");

  a_div_not_restarted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_min_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRIM) |-> (lo_q <= hi_q))
    else $error("window minimum above maximum");

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> ($past(state_q) == ST_OUT))
    else $error("result raised outside output step");
`endif

endmodule

>>> bench/sliding_trimmed_mean_filter_core_test.sv
// Self-checking bench for sliding_trimmed_mean_filter_core: directed and random words,
// checked against an in-bench model of the per-channel trimmed-mean windows.
// Depends on stmf_pkg and the filter RTL.
`timescale 1ns / 1ps

module sliding_trimmed_mean_filter_core_test;
  import stmf_pkg::*;

  localparam int unsigned WINDOW_MAX     = 32;
  localparam int unsigned NUM_CHANNELS   = 2;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 70;
  localparam int unsigned RANDOM_BLOCK   = 50;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                channel_i   = 1'b0;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0] filtered_o;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;

  // model state
  logic [SAMPLE_W-1:0] hist_mem [NUM_CHANNELS][WINDOW_MAX];
  logic [CFG_W-1:0]    win_len_reg = CFG_W'(WINDOW_LEN_RESET);
  logic [SAMPLE_W-1:0] pending_filtered [$];

  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;

  sliding_trimmed_mean_filter_core #(
    .WINDOW_MAX  (WINDOW_MAX),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .channel_i  (channel_i),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .filtered_o (filtered_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    foreach (hist_mem[c, i]) hist_mem[c][i] = '0;
  end

  // Shift the sample into the channel's active window and return the trimmed mean.
  function automatic logic [SAMPLE_W-1:0] advance_window(input logic ch,
                                                         input logic [SAMPLE_W-1:0] smp);
    int unsigned n;
    logic [31:0] total;
    logic [31:0] lo;
    logic [31:0] hi;
    n = win_len_reg;
    if (n < MIN_WINDOW) n = MIN_WINDOW;
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    for (int unsigned i = 0; i + 1 < n; i++) hist_mem[ch][i] = hist_mem[ch][i + 1];
    hist_mem[ch][n - 1] = smp;
    total = '0;
    lo    = 32'hFFFF;
    hi    = '0;
    for (int unsigned i = 0; i < n; i++) begin
      total += hist_mem[ch][i];
      if (hist_mem[ch][i] < lo) lo = hist_mem[ch][i];
      if (hist_mem[ch][i] > hi) hi = hist_mem[ch][i];
    end
    return SAMPLE_W'((total - lo - hi) / (n - 2));
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                 input logic [SAMPLE_W-1:0] got);
    $display("MISMATCH at %0t: %s, expected %0d got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Receiver: stall decision made every falling edge.
  initial begin
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_filtered.size() == 0)
          report_mismatch("result with no word pending", '0, filtered_o);
        else if (filtered_o !== pending_filtered[0])
          report_mismatch("filtered", pending_filtered.pop_front(), filtered_o);
        else
          void'(pending_filtered.pop_front());
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("sliding_trimmed_mean_filter_core test failed");
        $finish;
      end
    end
  end

  // Leaves in_valid_i high after acceptance; release_input drops it, the next call drops it only for a gap.
  task automatic send_word(input logic ch, input logic [SAMPLE_W-1:0] smp);
    int unsigned gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_filtered.push_back(advance_window(ch, smp));
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (pending_filtered.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_window_len(input logic [CFG_W-1:0] len);
    wait_drained();
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    win_len_reg = len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(3));        // tight cluster, many ties
      3:       return SAMPLE_W'(16'hFFFC + $urandom_range(3));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_len();
    case ($urandom_range(7))
      0:       return CFG_W'(0);
      1:       return CFG_W'(MIN_WINDOW);
      2:       return CFG_W'(WINDOW_MAX);
      3:       return '1;
      default: return CFG_W'($urandom_range(0, 63));
    endcase
  endfunction

  // Windows start at zero; default length applies.
  task automatic test_reset_windows();
    send_word(1'b0, 16'd1234);
    send_word(1'b1, 16'hFFFF);
    send_word(1'b0, 16'hFFFF);
    send_word(1'b1, 16'h0000);
  endtask

  // Full-scale and zero samples, ties at min and max.
  task automatic test_field_extremes();
    write_window_len(CFG_W'(3));
    repeat (3) send_word(1'b0, 16'hFFFF);
    send_word(1'b0, 16'h0000);
    send_word(1'b1, 16'h8000);
    send_word(1'b1, 16'h0001);
    send_word(1'b1, 16'h7FFF);
  endtask

  // Lengths below three and above the depth are clamped.
  task automatic test_length_clamp();
    write_window_len(CFG_W'(0));
    send_word(1'b0, 16'h5555);
    send_word(1'b1, 16'hAAAA);
    write_window_len(CFG_W'(1));
    send_word(1'b0, 16'h00FF);
    write_window_len(CFG_W'(2));
    send_word(1'b1, 16'hFF00);
    write_window_len('1);
    send_word(1'b0, 16'hFFFF);
    send_word(1'b1, 16'h0001);
    write_window_len(CFG_W'(33));
    send_word(1'b0, 16'h1234);
    write_window_len(CFG_W'(WINDOW_MAX));
    send_word(1'b1, 16'hFFFE);
  endtask

  // Shrinking leaves the upper entries untouched; growing brings them back in.
  task automatic test_length_change();
    write_window_len(CFG_W'(4));
    send_word(1'b0, 16'hFFFF);
    send_word(1'b0, 16'h0000);
    send_word(1'b0, 16'h4321);
    write_window_len(CFG_W'(9));
    send_word(1'b0, 16'h0010);
    send_word(1'b0, 16'hF000);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if (k % RANDOM_BLOCK == 0) write_window_len(pick_len());
      send_word(1'($urandom_range(1)), pick_sample());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 52;
    test_reset_windows();
    test_field_extremes();
    test_length_clamp();
    test_length_change();
    test_random_traffic(250);

    send_idle_pct = 52;
    recv_idle_pct = 34;
    test_random_traffic(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(250);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (pending_filtered.size() != 0)
      report_mismatch("word never arrived", pending_filtered.pop_front(), '0);

    if (mismatch_count == 0)
      $display("sliding_trimmed_mean_filter_core test passed");
    else
      $display("sliding_trimmed_mean_filter_core test failed");
    $finish;
  end

endmodule
